// ===== rtl/core/msfd_pkg.sv =====
// Shared types and constants for the sync-word frame deframer.
`timescale 1ns / 1ps

package msfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OUT_DATA_W = 3 * WORD_W + BYTE_W;

  // Sync word "AMB1" as it sits in the window, oldest byte on top.
  localparam logic [WORD_W-1:0] SYNC_WORD = 32'h414D_4231;

  // Header byte counter value of the final header byte.
  localparam logic [3:0] HDR_LAST = 4'd11;

  // Window fill saturates at four bytes.
  localparam logic [2:0] FILL_FULL = 3'd4;

  // Result kind codes.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] frame_id;
    logic [WORD_W-1:0] frame_flags;
    logic [WORD_W-1:0] payload_len;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
  } msfd_result_t;

endpackage

// ===== rtl/core/msfd_in_reg.sv =====
// Input register stage of the deframer: holds one accepted byte request.
`timescale 1ns / 1ps

module msfd_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [msfd_pkg::BYTE_W-1:0] in_tdata,
  input  logic                      adv,
  output logic                      hold_valid,
  output logic [msfd_pkg::BYTE_W-1:0] hold_byte
);
  import msfd_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // The stage can take a new byte when empty or when its byte moves on.
  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  a_adv_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> valid_r) else $error("byte advanced from an empty input stage");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> valid_r) else $error("accepted byte not held");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !in_tvalid) |=> !valid_r) else $error("input stage kept a consumed byte");

endmodule

// ===== rtl/core/msfd_parse.sv =====
// Frame parser: sync hunt, header assembly and payload counting.
`timescale 1ns / 1ps

module msfd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        big_endian,
  input  logic [msfd_pkg::BYTE_W-1:0] data_byte,
  input  logic                        adv,
  output logic                        res_valid,
  output msfd_pkg::msfd_result_t      res
);
  import msfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] win_r, win_nxt;
  logic [2:0]        fill_r, fill_nxt;
  logic [3:0]        hcnt_r, hcnt_nxt;
  logic [WORD_W-1:0] id_r, id_nxt;
  logic [WORD_W-1:0] flags_r, flags_nxt;
  logic [WORD_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] left_r, left_nxt;
  logic [1:0]        pos;
  logic [1:0]        lane;

  // ORs a byte into its lane; the word is cleared at its first byte.
  function automatic logic [WORD_W-1:0] put_byte(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] p,
                                                 input logic [1:0] ln,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] base;
    base = (p == 2'd0) ? '0 : w;
    return base | ({{(WORD_W-BYTE_W){1'b0}}, b} << {ln, 3'b000});
  endfunction

  assign pos  = hcnt_r[1:0];
  assign lane = big_endian ? ~pos : pos;

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    hcnt_nxt  = hcnt_r;
    id_nxt    = id_r;
    flags_nxt = flags_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_HEADER: begin
        case (hcnt_r[3:2])
          2'd0:    id_nxt    = put_byte(id_r, pos, lane, data_byte);
          2'd1:    flags_nxt = put_byte(flags_r, pos, lane, data_byte);
          default: len_nxt   = put_byte(len_r, pos, lane, data_byte);
        endcase
        if (hcnt_r != HDR_LAST) begin
          hcnt_nxt = hcnt_r + 4'd1;
        end else begin
          res_valid       = 1'b1;
          res.kind        = KIND_HEADER;
          res.frame_id    = id_nxt;
          res.frame_flags = flags_nxt;
          res.payload_len = len_nxt;
          hcnt_nxt        = '0;
          if (len_nxt == '0) begin
            // Empty frame: the header closes it and hunting resumes.
            res.last  = 1'b1;
            phase_nxt = PH_HUNT;
            win_nxt   = '0;
            fill_nxt  = '0;
            left_nxt  = '0;
          end else begin
            phase_nxt = PH_PAYLOAD;
            left_nxt  = len_nxt;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
        if (left_r <= {{(WORD_W-1){1'b0}}, 1'b1}) begin
          res.last  = 1'b1;
          phase_nxt = PH_HUNT;
          win_nxt   = '0;
          fill_nxt  = '0;
          hcnt_nxt  = '0;
          left_nxt  = '0;
        end else begin
          left_nxt = left_r - {{(WORD_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        win_nxt  = {win_r[WORD_W-BYTE_W-1:0], data_byte};
        fill_nxt = (fill_r >= FILL_FULL) ? FILL_FULL : fill_r + 3'd1;
        if (fill_r >= (FILL_FULL - 3'd1) && win_nxt == SYNC_WORD) begin
          win_nxt   = '0;
          fill_nxt  = '0;
          phase_nxt = PH_HEADER;
          hcnt_nxt  = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      fill_r  <= '0;
      hcnt_r  <= '0;
      id_r    <= '0;
      flags_r <= '0;
      len_r   <= '0;
      left_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      hcnt_r  <= hcnt_nxt;
      id_r    <= id_nxt;
      flags_r <= flags_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (left_r != '0)) else $error("payload phase with no bytes due");

  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= HDR_LAST) else $error("header counter out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL) else $error("window fill out of range");

  a_hcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER) |-> (hcnt_r == '0)) else $error("header count outside header");

  a_header_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_HEADER && hcnt_r == HDR_LAST) |=> (phase_r != PH_HEADER))
    else $error("header phase did not end after the last header byte");

endmodule

// ===== rtl/core/magic_sync_frame_deframer.sv =====
// Top level of the sync-word deframer: config register, stages and result register.
// Path: an accepted byte request is held in the input stage, then moves through the parser
// into the result register, from which the consumer takes it.
// Throughput: one byte request per cycle. While a result waits, bytes that make no result
// still move on; one that makes a result waits.
// Reset: synchronous, active low; both stages empty, hunting with a cleared window,
// header words zero, and big-endian header word assembly selected.
`timescale 1ns / 1ps

module magic_sync_frame_deframer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: bit 0 selects big-endian header words.
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [msfd_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [msfd_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] frame_id, [63:32] frame_flags,
                                                      // [95:64] payload_len,
                                                      // [103:96] payload_byte
  output logic                            out_tuser,  // kind: 0 header, 1 payload byte
  output logic                            out_tlast
);
  import msfd_pkg::*;

  logic              big_endian_r;
  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              res_valid;
  msfd_result_t      res;
  logic              out_free;
  logic              adv;
  logic              out_valid_r;
  logic              out_valid_nxt;
  msfd_result_t      out_r;

  // The user must write the byte-order register only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
    end else if (cfg_wr_en) begin
      big_endian_r <= cfg_wr_data;
    end
  end

  // A held byte moves through the parser when it makes no result, or when
  // the result register is empty or being drained this cycle.
  assign out_free = !out_valid_r || out_tready;
  assign adv      = hold_valid && (!res_valid || out_free);

  msfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  msfd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .big_endian (big_endian_r),
    .data_byte  (hold_byte),
    .adv        (adv),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: loads a new result or empties once the consumer takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.payload_byte, out_r.payload_len, out_r.frame_flags,
                       out_r.frame_id};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_valid) |-> out_free) else $error("result register overwritten");

  a_header_last_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_HEADER && !out_r.last) |-> (out_r.payload_len != '0))
    else $error("open header result with zero length");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_PAYLOAD) |-> (out_r.payload_len == '0))
    else $error("payload result carries header fields");

endmodule

// ===== bench/tb_magic_sync_frame_deframer.sv =====
// Self-checking testbench for the sync-word frame deframer.
`timescale 1ns / 1ps

module tb_magic_sync_frame_deframer;
  import msfd_pkg::*;

  // The driver waits for quiet before a register write or pause, so that bytes which cause no
  // result have left the pipeline by then.
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BYTES  = 650;
  localparam int MAX_REPORTS   = 10;

  // Commands that feed the driver: a byte request, a register write, a pause
  // until every expected result has come, or a change of the idling pattern.
  typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN, OP_MODE} stim_op_t;

  typedef struct {
    stim_op_t    op;
    logic [7:0]  value;
    int unsigned idle_pct;
    int unsigned stall_pct;
  } stim_cmd_t;

  // Parser states of the local deframer copy.
  typedef enum logic [1:0] {ST_HUNT = 2'd0, ST_HEADER = 2'd1, ST_PAYLOAD = 2'd2} parse_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  magic_sync_frame_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Pending stimulus, and the header and payload results still owed by the block.
  stim_cmd_t    stim_q[$];
  msfd_result_t frame_results_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  logic        next_valid;
  logic        next_cfg;

  // Local copy of the deframer state and of its one register.
  logic         be_words = 1'b1;
  parse_state_t parse_state = ST_HUNT;
  logic [31:0]  sync_shift = '0;
  logic [2:0]   shift_fill = '0;
  logic [3:0]   hdr_count = '0;
  logic [31:0]  hdr_word [3] = '{default: '0};
  logic [31:0]  bytes_due = '0;

  // Frame end: the sync window starts empty, so a sync word never spans a frame end.
  function automatic void restart_hunt();
    sync_shift  = '0;
    shift_fill  = '0;
    parse_state = ST_HUNT;
    hdr_count   = '0;
    bytes_due   = '0;
  endfunction

  // Advances the deframer copy by one byte and queues the result that the byte causes.
  function automatic void deframe_byte(input logic [7:0] data_in);
    msfd_result_t res;
    logic [1:0]   pos;
    int unsigned  shift;

    res = '0;
    case (parse_state)
      ST_HEADER: begin
        // Each byte lands where the register points at its arrival; the word is
        // cleared at its first byte and the rest are ORed in.
        pos   = hdr_count[1:0];
        shift = be_words ? (3 - pos) * 8 : pos * 8;
        if (pos == 2'd0) begin
          hdr_word[hdr_count[3:2]] = '0;
        end
        hdr_word[hdr_count[3:2]] |= 32'(data_in) << shift;
        if (hdr_count != HDR_LAST) begin
          hdr_count++;
        end else begin
          res.kind        = KIND_HEADER;
          res.frame_id    = hdr_word[0];
          res.frame_flags = hdr_word[1];
          res.payload_len = hdr_word[2];
          // A zero-length frame ends with its header.
          res.last        = (hdr_word[2] == '0);
          frame_results_q.push_back(res);
          if (res.last) begin
            restart_hunt();
          end else begin
            parse_state = ST_PAYLOAD;
            hdr_count   = '0;
            bytes_due   = hdr_word[2];
          end
        end
      end
      ST_PAYLOAD: begin
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_in;
        res.last         = (bytes_due <= 32'd1);
        frame_results_q.push_back(res);
        if (res.last) begin
          restart_hunt();
        end else begin
          bytes_due--;
        end
      end
      default: begin
        sync_shift = {sync_shift[23:0], data_in};
        if (shift_fill < FILL_FULL) begin
          shift_fill++;
        end
        if (shift_fill >= FILL_FULL && sync_shift == SYNC_WORD) begin
          sync_shift  = '0;
          shift_fill  = '0;
          parse_state = ST_HEADER;
          hdr_count   = '0;
        end else begin
          parse_state = ST_HUNT;
        end
      end
    endcase
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endtask

  // Driver: presents byte requests and register writes from the stimulus queue. A
  // request is held until accepted; register writes and pauses wait until the block
  // has been quiet for a while with nothing left to deliver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
      end
      if (in_tvalid || cfg_wr_en || frame_results_q.size() != 0) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (!(in_tvalid && !in_tready)) begin
        next_valid = 1'b0;
        next_cfg   = 1'b0;
        if (stim_q.size() != 0) begin
          case (stim_q[0].op)
            OP_BYTE: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                next_valid = 1'b1;
                in_tdata <= stim_q[0].value;
                void'(stim_q.pop_front());
              end
            end
            OP_MODE: begin
              send_idle_pct  = stim_q[0].idle_pct;
              sink_stall_pct = stim_q[0].stall_pct;
              void'(stim_q.pop_front());
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                if (stim_q[0].op == OP_CFG) begin
                  // The write lands at the next edge, before any later byte request.
                  next_cfg = 1'b1;
                  cfg_wr_data <= stim_q[0].value[0];
                  be_words = stim_q[0].value[0];
                end
                quiet_cycles = 0;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
        in_tvalid <= next_valid;
        cfg_wr_en <= next_cfg;
      end
    end
  end

  // Monitor: stalls the result side at random and checks every accepted result
  // against the oldest expectation.
  always @(posedge clk) begin
    msfd_result_t got;
    msfd_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind         = out_tuser;
        got.frame_id     = out_tdata[31:0];
        got.frame_flags  = out_tdata[63:32];
        got.payload_len  = out_tdata[95:64];
        got.payload_byte = out_tdata[103:96];
        got.last         = out_tlast;
        if (frame_results_q.size() == 0) begin
          flag_error($sformatf("unexpected result: kind=%0d id=%h flags=%h len=%h data=%h last=%0d",
                               got.kind, got.frame_id, got.frame_flags, got.payload_len,
                               got.payload_byte, got.last));
        end else begin
          want = frame_results_q.pop_front();
          if (got.kind !== want.kind || got.frame_id !== want.frame_id ||
              got.frame_flags !== want.frame_flags || got.payload_len !== want.payload_len ||
              got.payload_byte !== want.payload_byte || got.last !== want.last) begin
            flag_error($sformatf({"mismatch: expected kind=%0d id=%h flags=%h len=%h data=%h ",
                                  "last=%0d, got kind=%0d id=%h flags=%h len=%h data=%h last=%0d"},
                                 want.kind, want.frame_id, want.frame_flags, want.payload_len,
                                 want.payload_byte, want.last, got.kind, got.frame_id,
                                 got.frame_flags, got.payload_len, got.payload_byte, got.last));
          end
        end
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus builders. The byte order of header words follows the register value
  // that the stimulus has set up to that point.
  logic        stim_be = 1'b1;
  int unsigned bytes_queued = 0;

  task automatic queue_byte(input logic [7:0] value);
    stim_cmd_t cmd;
    cmd = '{op: OP_BYTE, value: value, idle_pct: 0, stall_pct: 0};
    stim_q.push_back(cmd);
    bytes_queued++;
  endtask

  task automatic queue_cfg(input logic value);
    stim_cmd_t cmd;
    cmd = '{op: OP_CFG, value: {7'd0, value}, idle_pct: 0, stall_pct: 0};
    stim_q.push_back(cmd);
    stim_be = value;
  endtask

  task automatic queue_drain();
    stim_cmd_t cmd;
    cmd = '{op: OP_DRAIN, value: '0, idle_pct: 0, stall_pct: 0};
    stim_q.push_back(cmd);
  endtask

  task automatic queue_mode(input int unsigned idle_pct, input int unsigned stall_pct);
    stim_cmd_t cmd;
    cmd = '{op: OP_MODE, value: '0, idle_pct: idle_pct, stall_pct: stall_pct};
    stim_q.push_back(cmd);
  endtask

  task automatic queue_sync();
    for (int k = 3; k >= 0; k--) begin
      queue_byte(SYNC_WORD[8*k +: 8]);
    end
  endtask

  task automatic queue_word(input logic [31:0] value);
    for (int k = 0; k < 4; k++) begin
      queue_byte(stim_be ? value[8*(3-k) +: 8] : value[8*k +: 8]);
    end
  endtask

  // A well-formed frame; pay_count may be below len only for a frame that the run
  // never finishes.
  task automatic queue_frame(input logic [31:0] id, input logic [31:0] flags,
                             input logic [31:0] len, input int unsigned pay_count);
    queue_sync();
    queue_word(id);
    queue_word(flags);
    queue_word(len);
    for (int unsigned k = 0; k < pay_count; k++) begin
      queue_byte(8'($urandom_range(255)));
    end
  endtask

  // Line noise never holds the sync word's final byte, so it cannot start a frame.
  task automatic queue_noise(input int unsigned count);
    logic [7:0] value;
    for (int unsigned k = 0; k < count; k++) begin
      value = 8'($urandom_range(255));
      if (value == SYNC_WORD[7:0]) begin
        value ^= 8'h01;
      end
      queue_byte(value);
    end
  endtask

  // Random traffic: mostly whole frames with random headers and payloads, with some noise,
  // near misses of the sync word, register writes and pauses in between.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] len;
    logic [7:0]  miss;

    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        queue_noise($urandom_range(1, 6));
      end else if (pick < 20) begin
        // Sync word broken at its last byte.
        miss = 8'($urandom_range(255));
        if (miss == SYNC_WORD[7:0]) begin
          miss ^= 8'h80;
        end
        queue_byte(SYNC_WORD[31:24]);
        queue_byte(SYNC_WORD[23:16]);
        queue_byte(SYNC_WORD[15:8]);
        queue_byte(miss);
      end else if (pick < 26) begin
        queue_cfg(1'($urandom_range(1)));
      end else if (pick < 28) begin
        queue_drain();
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          len = '0;
        end else if (pick < 75) begin
          len = $urandom_range(1, 6);
        end else if (pick < 95) begin
          len = $urandom_range(7, 24);
        end else begin
          len = $urandom_range(25, 64);
        end
        queue_frame($urandom(), $urandom(), len, len);
      end
    end
  endtask

  initial begin
    // Directed part, with no idling: line extremes, a near miss, a sync word that
    // starts one byte late, a zero-length frame and a one-byte frame.
    queue_mode(0, 0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(SYNC_WORD[31:24]);
    queue_byte(SYNC_WORD[23:16]);
    queue_byte(SYNC_WORD[15:8]);
    queue_byte(8'h32);
    queue_byte(SYNC_WORD[31:24]);
    queue_frame(32'h0123_4567, 32'h89AB_CDEF, 32'd0, 0);
    queue_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1);
    // The tail of a sync word right after a frame end must not match.
    queue_byte(SYNC_WORD[15:8]);
    queue_byte(SYNC_WORD[7:0]);
    // Byte order switched in the middle of the id word: two bytes land little-endian,
    // the other two big-endian.
    queue_cfg(1'b0);
    queue_sync();
    queue_byte(8'hA5);
    queue_byte(8'h5A);
    queue_cfg(1'b1);
    queue_byte(8'hC3);
    queue_byte(8'h3C);
    queue_word(32'h0000_0000);
    queue_word(32'd3);
    queue_byte(8'h00);
    queue_byte(8'h80);
    queue_byte(8'h7F);

    // Random part in phases of different idling, with the register set to each
    // value in turn and a full pause once the sender has been busy for a while.
    queue_cfg(1'b0);
    queue_random_traffic(RANDOM_BYTES / 5);
    queue_drain();
    queue_mode(75, 0);
    queue_cfg(1'b1);
    queue_random_traffic(RANDOM_BYTES / 5);
    queue_mode(0, 75);
    queue_cfg(1'b0);
    queue_random_traffic(RANDOM_BYTES / 5);
    queue_mode(18, 18);
    queue_cfg(1'b1);
    queue_random_traffic(RANDOM_BYTES / 5);
    queue_mode(0, 0);
    queue_random_traffic(RANDOM_BYTES / 5);

    // The largest length: the frame stays open, so only its first bytes are sent.
    queue_cfg(1'b1);
    queue_frame(32'h0000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 12);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid || frame_results_q.size() != 0) begin
      @(negedge clk);
    end
    // Let the pipeline empty so that a stray result still gets caught.
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS magic_sync_frame_deframer");
    end else begin
      $display("FAIL magic_sync_frame_deframer");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("FAIL magic_sync_frame_deframer");
    $finish;
  end

endmodule
